FILE: hw/rtl/dmc_pkg.sv
// Shared types and constants for the depth-first maze carver.
// No dependencies; used by dfs_maze_carver and its testbench.
package dmc_pkg;

  localparam int FIELD_W     = 4;   // row / column field width on the stream
  localparam int DIR_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int IN_TUSER_W  = 1;

  // visit tags: an entry is visited when it holds the current epoch
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    STAT_CARVED  = 3'd0,
    STAT_RETRY   = 3'd1,
    STAT_BACK    = 3'd2,
    STAT_DONE    = 3'd3,
    STAT_STARTED = 3'd4,
    STAT_IGNORED = 3'd5
  } dmc_status_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_RD_A  = 5'b00100,
    ST_RD_B  = 5'b01000,
    ST_EVAL  = 5'b10000
  } dmc_state_t;

endpackage

FILE: hw/rtl/dmc_visit_mem.sv
// Visit tag memory: one write port, two registered read ports.
// Standalone; instantiated by dfs_maze_carver.
module dmc_visit_mem #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

FILE: hw/rtl/dmc_stack_mem.sv
// Path stack memory: one write port, one registered read port.
// Standalone; instantiated by dfs_maze_carver.
module dmc_stack_mem #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/dfs_maze_carver.sv
// Depth-first maze carver, top level. Uses dmc_pkg, dmc_visit_mem, dmc_stack_mem.
// Step request: the four neighbour tags are read in states ST_RD_A and ST_RD_B through the
// two read ports of the tag memory, then the result is formed in ST_EVAL; the next request is taken only as it commits.
// Start request: goes from accept to ST_EVAL, one a cycle while the output is not stalled;
// the first start after reset and every 255th start after it first sweep the tag memory
// (ST_CLEAR), input not ready. Reset clears control state only.
module dfs_maze_carver #(
  parameter int GRID_SIDE = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [3:0] start_row, [7:4] start_col, [9:8] dir, [15:10] zero
  input  logic [dmc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [0] op
  input  logic [dmc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [3:0] cur_row, [7:4] cur_col, [9:8] carved_dir, [15:10] zero
  output logic [dmc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [2:0] status
  output logic [dmc_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int CW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int AW    = 2 * CW;
  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int SW    = $clog2(CELLS);
  localparam int NW    = $clog2(CELLS + 1);
  localparam int FW    = dmc_pkg::FIELD_W;
  localparam int EW    = dmc_pkg::EPOCH_W;
  localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);
  localparam logic [NW-1:0] CELLS_N = NW'(CELLS);

  dmc_pkg::dmc_state_t state, state_next;

  // request held while it is worked on
  logic          op_q;
  logic [FW-1:0] srow_q, scol_q;
  logic [1:0]    dir_q;

  logic [CW-1:0] here_row, here_col, here_row_next, here_col_next;
  logic [NW-1:0] stack_top, stack_top_next, visit_count, visit_count_next;
  logic          active, active_next;
  logic [EW-1:0] epoch, epoch_next;
  logic [AW-1:0] clr_cnt;
  logic          vis_down_q, vis_right_q;

  logic          accept, commit;
  logic [EW-1:0] vq0, vq1;
  logic [AW-1:0] sq;
  logic          vm_we, vm_re, st_we, st_re;
  logic [AW-1:0] vm_waddr, vm_raddr0, vm_raddr1;
  logic [EW-1:0] vm_wdata;
  logic [NW-1:0] top_m1;

  logic [CW-1:0] dn_row, up_row, rt_col, lf_col, nb_row, nb_col, srow_sat, scol_sat;
  logic [3:0]    open_dir;
  logic          down_ok, right_ok, left_ok, up_ok;
  dmc_pkg::dmc_status_t status;
  logic [1:0]    carved;
  logic [CW+FW-1:0] row_ext, col_ext;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign commit = (state == dmc_pkg::ST_EVAL) && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = (state == dmc_pkg::ST_IDLE) || commit;
  assign top_m1 = stack_top - NW'(1);

  // neighbour coordinates; out-of-grid ones wrap and are masked by the _ok flags
  assign dn_row   = here_row + CW'(1);
  assign up_row   = here_row - CW'(1);
  assign rt_col   = here_col + CW'(1);
  assign lf_col   = here_col - CW'(1);
  assign down_ok  = here_row != LAST;
  assign right_ok = here_col != LAST;
  assign left_ok  = here_col != '0;
  assign up_ok    = here_row != '0;

  // reads never share a cycle with a write, so no bypass is needed
  assign vm_re     = (state == dmc_pkg::ST_RD_A) || (state == dmc_pkg::ST_RD_B);
  assign vm_raddr0 = (state == dmc_pkg::ST_RD_A) ? {dn_row, here_col} : {here_row, lf_col};
  assign vm_raddr1 = (state == dmc_pkg::ST_RD_A) ? {here_row, rt_col} : {up_row, here_col};
  assign st_re     = (state == dmc_pkg::ST_RD_A);

  always_comb begin
    open_dir[0] = down_ok && !vis_down_q;
    open_dir[1] = right_ok && !vis_right_q;
    open_dir[2] = left_ok && (vq0 != epoch);
    open_dir[3] = up_ok && (vq1 != epoch);

    case (dir_q)
      dmc_pkg::DIR_DOWN:  begin nb_row = dn_row;   nb_col = here_col; end
      dmc_pkg::DIR_RIGHT: begin nb_row = here_row; nb_col = rt_col;   end
      dmc_pkg::DIR_LEFT:  begin nb_row = here_row; nb_col = lf_col;   end
      default:            begin nb_row = up_row;   nb_col = here_col; end
    endcase

    srow_sat = (32'(srow_q) >= 32'(GRID_SIDE)) ? LAST : CW'(srow_q);
    scol_sat = (32'(scol_q) >= 32'(GRID_SIDE)) ? LAST : CW'(scol_q);
  end

  always_comb begin
    here_row_next    = here_row;
    here_col_next    = here_col;
    stack_top_next   = stack_top;
    visit_count_next = visit_count;
    active_next      = active;
    epoch_next       = epoch;
    status           = dmc_pkg::STAT_IGNORED;
    carved           = dmc_pkg::DIR_DOWN;
    vm_we            = 1'b0;
    vm_waddr         = clr_cnt;
    vm_wdata         = '0;
    st_we            = 1'b0;

    if (state == dmc_pkg::ST_CLEAR) begin
      vm_we = 1'b1;
    end else if (commit) begin
      if (op_q == dmc_pkg::OP_START) begin
        epoch_next       = (epoch == dmc_pkg::EPOCH_MAX) ? dmc_pkg::EPOCH_ONE
                                                         : epoch + EW'(1);
        here_row_next    = srow_sat;
        here_col_next    = scol_sat;
        stack_top_next   = '0;
        visit_count_next = NW'(1);
        active_next      = 1'b1;
        vm_we            = 1'b1;
        vm_waddr         = {srow_sat, scol_sat};
        vm_wdata         = epoch_next;
        status           = dmc_pkg::STAT_STARTED;
      end else if (!active) begin
        status = dmc_pkg::STAT_IGNORED;
      end else if (visit_count >= CELLS_N) begin
        status = dmc_pkg::STAT_DONE;
      end else if (|open_dir) begin
        if (open_dir[dir_q]) begin
          if (stack_top < CELLS_N) begin
            st_we          = 1'b1;
            stack_top_next = stack_top + NW'(1);
          end
          vm_we            = 1'b1;
          vm_waddr         = {nb_row, nb_col};
          vm_wdata         = epoch;
          here_row_next    = nb_row;
          here_col_next    = nb_col;
          visit_count_next = visit_count + NW'(1);
          carved           = dir_q;
          status           = dmc_pkg::STAT_CARVED;
        end else begin
          status = dmc_pkg::STAT_RETRY;
        end
      end else begin
        // dead end: return to the cell on top of the stack
        if (stack_top != '0) begin
          stack_top_next = top_m1;
          here_row_next  = sq[AW-1:CW];
          here_col_next  = sq[CW-1:0];
        end
        status = dmc_pkg::STAT_BACK;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dmc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = dmc_pkg::ST_RD_A;
        end
      end
      dmc_pkg::ST_CLEAR: begin
        if (clr_cnt == {AW{1'b1}}) begin
          state_next = dmc_pkg::ST_EVAL;
        end
      end
      dmc_pkg::ST_RD_A: state_next = dmc_pkg::ST_RD_B;
      dmc_pkg::ST_RD_B: state_next = dmc_pkg::ST_EVAL;
      dmc_pkg::ST_EVAL: begin
        if (commit) begin
          state_next = accept ? dmc_pkg::ST_RD_A : dmc_pkg::ST_IDLE;
        end
      end
      default: state_next = dmc_pkg::ST_IDLE;
    endcase
    // a start only sweeps when its epoch would wrap
    if (accept && s_axis_tuser[0] == dmc_pkg::OP_START) begin
      state_next = (epoch_next == dmc_pkg::EPOCH_MAX) ? dmc_pkg::ST_CLEAR : dmc_pkg::ST_EVAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dmc_pkg::ST_IDLE;
      here_row      <= '0;
      here_col      <= '0;
      stack_top     <= '0;
      visit_count   <= '0;
      active        <= 1'b0;
      epoch         <= dmc_pkg::EPOCH_MAX;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state       <= state_next;
      here_row    <= here_row_next;
      here_col    <= here_col_next;
      stack_top   <= stack_top_next;
      visit_count <= visit_count_next;
      active      <= active_next;
      epoch       <= epoch_next;
      if (state == dmc_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (commit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign row_ext = {{FW{1'b0}}, here_row_next};
  assign col_ext = {{FW{1'b0}}, here_col_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= s_axis_tuser[0];
      srow_q <= s_axis_tdata[3:0];
      scol_q <= s_axis_tdata[7:4];
      dir_q  <= s_axis_tdata[9:8];
    end
    if (state == dmc_pkg::ST_RD_B) begin
      vis_down_q  <= (vq0 == epoch);
      vis_right_q <= (vq1 == epoch);
    end
    if (commit) begin
      m_axis_tuser <= status;
      m_axis_tdata <= {{(dmc_pkg::OUT_TDATA_W - 2 * FW - dmc_pkg::DIR_W){1'b0}},
                       carved, col_ext[FW-1:0], row_ext[FW-1:0]};
    end
  end

  dmc_visit_mem #(
    .ADDR_W (AW),
    .DATA_W (EW)
  ) u_visit (
    .clk    (clk),
    .we     (vm_we),
    .waddr  (vm_waddr),
    .wdata  (vm_wdata),
    .re     (vm_re),
    .raddr0 (vm_raddr0),
    .raddr1 (vm_raddr1),
    .rdata0 (vq0),
    .rdata1 (vq1)
  );

  dmc_stack_mem #(
    .ADDR_W (SW),
    .DATA_W (AW)
  ) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (stack_top[SW-1:0]),
    .wdata ({here_row, here_col}),
    .re    (st_re),
    .raddr (top_m1[SW-1:0]),
    .rdata (sq)
  );

endmodule

FILE: verif/dfs_maze_carver_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dfs_maze_carver: requests on the input stream, carve
// results predicted in step and checked on the output stream. Depends on dmc_pkg.
module dfs_maze_carver_tb;

  localparam int GRID        = 16;
  localparam int CELLS       = GRID * GRID;
  localparam int REQ_TARGET  = 1200;
  localparam int CYCLE_CAP   = 200000;
  localparam int DIR_W       = dmc_pkg::DIR_W;
  localparam int IN_TDATA_W  = dmc_pkg::IN_TDATA_W;
  localparam int IN_TUSER_W  = dmc_pkg::IN_TUSER_W;
  localparam int OUT_TDATA_W = dmc_pkg::OUT_TDATA_W;
  localparam int STATUS_W    = dmc_pkg::STATUS_W;

  typedef struct packed {
    dmc_pkg::dmc_status_t status;
    logic [3:0]           row;
    logic [3:0]           col;
    logic [DIR_W-1:0]     cdir;
  } carve_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // [3:0] start_row, [7:4] start_col, [9:8] dir
  logic [IN_TUSER_W-1:0] s_axis_tuser = '0;   // [0] op
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [3:0] cur_row, [7:4] cur_col, [9:8] carved_dir
  logic [STATUS_W-1:0] m_axis_tuser;          // [2:0] status

  // predicted maze state
  bit         visited [CELLS];
  logic [7:0] path [CELLS];
  int         path_depth;
  int         visit_total;
  int         here;
  bit         live;

  carve_result_t pending_results [$];
  int  mismatches = 0;
  int  req_count = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;

  dfs_maze_carver #(.GRID_SIDE(GRID)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // cell one step away in direction d, if it lies inside the grid
  function automatic bit step_target(input int pos, input logic [DIR_W-1:0] d,
                                     output int nb);
    int r;
    int c;
    r = pos / GRID;
    c = pos % GRID;
    nb = pos;
    case (d)
      dmc_pkg::DIR_DOWN:  if (r + 1 >= GRID) return 1'b0; else r++;
      dmc_pkg::DIR_RIGHT: if (c + 1 >= GRID) return 1'b0; else c++;
      dmc_pkg::DIR_LEFT:  if (c == 0) return 1'b0; else c--;
      default:            if (r == 0) return 1'b0; else r--;
    endcase
    nb = r * GRID + c;
    return 1'b1;
  endfunction

  function automatic bit is_open(input int pos, input logic [DIR_W-1:0] d);
    int nb;
    if (!step_target(pos, d, nb)) return 1'b0;
    return !visited[nb];
  endfunction

  task automatic predict_carve(input logic op, input logic [3:0] r, input logic [3:0] c,
                               input logic [DIR_W-1:0] d, output carve_result_t res);
    int nb;
    bit any_open;
    res.cdir = dmc_pkg::DIR_DOWN;
    any_open = is_open(here, dmc_pkg::DIR_DOWN) || is_open(here, dmc_pkg::DIR_RIGHT) ||
               is_open(here, dmc_pkg::DIR_LEFT) || is_open(here, dmc_pkg::DIR_UP);
    if (op == dmc_pkg::OP_START) begin
      foreach (visited[i]) visited[i] = 1'b0;
      path_depth = 0;
      here = int'(r) * GRID + int'(c);
      visited[here] = 1'b1;
      visit_total = 1;
      live = 1'b1;
      res.status = dmc_pkg::STAT_STARTED;
    end else if (!live) begin
      res.status = dmc_pkg::STAT_IGNORED;
    end else if (visit_total >= CELLS) begin
      res.status = dmc_pkg::STAT_DONE;
    end else if (any_open) begin
      if (is_open(here, d)) begin
        void'(step_target(here, d, nb));
        if (path_depth < CELLS) begin
          path[path_depth] = here[7:0];
          path_depth++;
        end
        visited[nb] = 1'b1;
        here = nb;
        visit_total++;
        res.cdir = d;
        res.status = dmc_pkg::STAT_CARVED;
      end else begin
        res.status = dmc_pkg::STAT_RETRY;
      end
    end else begin
      if (path_depth > 0) begin
        path_depth--;
        here = int'(path[path_depth]);
      end
      res.status = dmc_pkg::STAT_BACK;
    end
    res.row = 4'(here / GRID);
    res.col = 4'(here % GRID);
  endtask

  // mostly heads for an unvisited neighbour so that the walk gets deep into the grid
  function automatic logic [DIR_W-1:0] guided_dir(input int pct);
    logic [DIR_W-1:0] open_dirs [$];
    for (int d = 0; d < 4; d++)
      if (is_open(here, DIR_W'(d))) open_dirs.push_back(DIR_W'(d));
    if (open_dirs.size() == 0 || $urandom_range(99) >= pct) return DIR_W'($urandom_range(3));
    return open_dirs[$urandom_range(open_dirs.size() - 1)];
  endfunction

  task automatic send_req(input logic op, input logic [3:0] r, input logic [3:0] c,
                          input logic [DIR_W-1:0] d);
    carve_result_t res;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - 10){1'b0}}, d, c, r};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_carve(op, r, c, d, res);
    pending_results.push_back(res);
    req_count++;
  endtask

  always @(negedge clk) m_axis_tready <= no_idle || ($urandom_range(99) >= 38);

  always @(posedge clk) begin
    carve_result_t exp_res;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d row %0d col %0d", $time,
                 m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[7:4]);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tuser !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status,
                   m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[3:0] !== exp_res.row) begin
          $display("%0t: cur_row expected %0d actual %0d", $time, exp_res.row,
                   m_axis_tdata[3:0]);
          mismatches++;
        end
        if (m_axis_tdata[7:4] !== exp_res.col) begin
          $display("%0t: cur_col expected %0d actual %0d", $time, exp_res.col,
                   m_axis_tdata[7:4]);
          mismatches++;
        end
        if (m_axis_tdata[9:8] !== exp_res.cdir) begin
          $display("%0t: carved_dir expected %0d actual %0d", $time, exp_res.cdir,
                   m_axis_tdata[9:8]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // steps before any start are ignored
  task automatic test_steps_before_start();
    for (int d = 0; d < 4; d++) send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, DIR_W'(d));
  endtask

  // corners and edges: retries off the grid, carves inward, retry into a visited cell
  task automatic test_grid_edges();
    send_req(dmc_pkg::OP_START, 4'd0, 4'd0, dmc_pkg::DIR_UP);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_UP);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_LEFT);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_RIGHT);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_DOWN);
    send_req(dmc_pkg::OP_START, 4'd15, 4'd15, dmc_pkg::DIR_DOWN);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_DOWN);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_RIGHT);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_LEFT);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_UP);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_RIGHT);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_DOWN);
    send_req(dmc_pkg::OP_START, 4'd0, 4'd15, dmc_pkg::DIR_RIGHT);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_RIGHT);
    send_req(dmc_pkg::OP_START, 4'd15, 4'd0, dmc_pkg::DIR_LEFT);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_LEFT);
    send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, dmc_pkg::DIR_DOWN);
    send_req(dmc_pkg::OP_START, 4'd7, 4'd8, dmc_pkg::DIR_RIGHT);
    for (int d = 0; d < 4; d++) send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, DIR_W'(d));
  endtask

  // one maze carved to the end, then steps after completion
  task automatic test_full_maze();
    no_idle = 1'b1;
    send_req(dmc_pkg::OP_START, 4'($urandom_range(15)), 4'($urandom_range(15)),
             DIR_W'($urandom_range(3)));
    while (visit_total < CELLS) begin
      if (req_count > 330) no_idle = 1'b0;
      send_req(dmc_pkg::OP_STEP, 4'($urandom), 4'($urandom), guided_dir(85));
    end
    no_idle = 1'b0;
    for (int i = 0; i < 3; i++)
      send_req(dmc_pkg::OP_STEP, 4'd0, 4'd0, DIR_W'($urandom_range(3)));
  endtask

  // short random walks, broken by restarts and plain random steps
  task automatic test_random_walks();
    int roll;
    while (req_count < REQ_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 4)
        send_req(dmc_pkg::OP_START, 4'($urandom), 4'($urandom), DIR_W'($urandom));
      else if (roll < 10)
        send_req(dmc_pkg::OP_STEP, 4'($urandom), 4'($urandom), DIR_W'($urandom));
      else
        send_req(dmc_pkg::OP_STEP, 4'($urandom), 4'($urandom), guided_dir(75));
    end
  endtask

  initial begin
    path_depth  = 0;
    visit_total = 0;
    here        = 0;
    live        = 1'b0;
    foreach (visited[i]) visited[i] = 1'b0;
    foreach (path[i]) path[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_steps_before_start();
    test_grid_edges();
    test_full_maze();
    test_random_walks();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
